// ----- rtl/tkbfd_pkg.sv -----
// ----------------------------------------------------------------------------
// tkbfd_pkg
// Types and constants shared by the byte frame deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tkbfd_pkg;

  localparam logic [7:0] HDR_COLUMN = 8'hFF;
  localparam logic [7:0] HDR_COLOUR = 8'h01;
  localparam logic [7:0] HDR_ALIGN  = 8'h03;
  localparam logic [7:0] TRAILER    = 8'hFE;

  localparam logic [1:0] LEN_LONG  = 2'd3;
  localparam logic [1:0] LEN_SHORT = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_TRAILER = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    KIND_COLUMN = 2'd0,
    KIND_COLOUR = 2'd1,
    KIND_ALIGN  = 2'd2
  } kind_e;

  typedef struct packed {
    logic       frame_done;
    logic [1:0] frame_kind;
    logic [7:0] payload_first;
    logic [7:0] payload_second;
    logic [7:0] payload_third;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/tkbfd_if.sv -----
// ----------------------------------------------------------------------------
// tkbfd_in_if / tkbfd_out_if
// Valid/ready channels for received bytes and for frame results.
// ----------------------------------------------------------------------------
`default_nettype none

interface tkbfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tkbfd_out_if;
  logic       valid;
  logic       ready;
  logic       frame_done;
  logic [1:0] frame_kind;
  logic [7:0] payload_first;
  logic [7:0] payload_second;
  logic [7:0] payload_third;

  modport source (output valid, output frame_done, output frame_kind,
                  output payload_first, output payload_second,
                  output payload_third, input ready);
  modport sink   (input valid, input frame_done, input frame_kind,
                  input payload_first, input payload_second,
                  input payload_third, output ready);
endinterface

`default_nettype wire

// ----- rtl/three_kind_byte_frame_deframer_top.sv -----
// ----------------------------------------------------------------------------
// three_kind_byte_frame_deframer_top
// Header/payload/trailer deframer for a byte stream with three frame kinds.
// ----------------------------------------------------------------------------
// Every received byte yields exactly one result transfer, through the input
// register and then the result register; a new byte can be accepted every
// cycle unless the result channel stalls. The frame state machine handles one byte
// per clock between the input register and the result register. Bytes 0xFF,
// 0x01 and 0x03 open column, colour-block and alignment frames while idle;
// after the payload, 0xFE closes the frame and its result has frame_done set.
`default_nettype none

module three_kind_byte_frame_deframer_top (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tkbfd_in_if.sink   in_i,
  tkbfd_out_if.source out_o
);

  logic               stage_valid;
  logic [7:0]         stage_byte;
  logic               can_load;
  logic               step;
  tkbfd_pkg::result_t parse_result;
  tkbfd_pkg::result_t out_result;

  assign step = stage_valid && can_load;

  tkbfd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_byte_i  (in_i.rx_byte),
    .in_ready_o (in_i.ready),
    .take_i     (step),
    .valid_o    (stage_valid),
    .byte_o     (stage_byte)
  );

  tkbfd_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (stage_byte),
    .result_o (parse_result)
  );

  tkbfd_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (stage_valid),
    .result_i   (parse_result),
    .can_load_o (can_load),
    .valid_o    (out_o.valid),
    .ready_i    (out_o.ready),
    .result_o   (out_result)
  );

  assign out_o.frame_done     = out_result.frame_done;
  assign out_o.frame_kind     = out_result.frame_kind;
  assign out_o.payload_first  = out_result.payload_first;
  assign out_o.payload_second = out_result.payload_second;
  assign out_o.payload_third  = out_result.payload_third;

endmodule

`default_nettype wire

// ----- rtl/tkbfd_in_reg.sv -----
// ----------------------------------------------------------------------------
// tkbfd_in_reg
// Input register stage that holds one received byte until it is parsed.
// ----------------------------------------------------------------------------
`default_nettype none

module tkbfd_in_reg (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [7:0] in_byte_i,
  output logic            in_ready_o,
  input  wire logic       take_i,
  output logic            valid_o,
  output logic [7:0]      byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       load;

  // The stage frees up in the same cycle its byte moves on.
  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= in_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

`default_nettype wire

// ----- rtl/tkbfd_parse.sv -----
// ----------------------------------------------------------------------------
// tkbfd_parse
// Frame state machine: header search, payload capture and trailer match.
// ----------------------------------------------------------------------------
`default_nettype none

module tkbfd_parse (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [7:0]        byte_i,
  output tkbfd_pkg::result_t     result_o
);

  tkbfd_pkg::phase_e phase_q, phase_d;
  tkbfd_pkg::kind_e  kind_q, kind_d;
  logic [1:0]        count_q, count_d;
  logic [7:0]        store_q [3];
  logic [7:0]        store_d [3];
  logic              is_align;
  logic [1:0]        len;
  logic [1:0]        slot;

  assign is_align = (kind_q != tkbfd_pkg::KIND_COLUMN) && (kind_q != tkbfd_pkg::KIND_COLOUR);
  assign len      = is_align ? tkbfd_pkg::LEN_SHORT : tkbfd_pkg::LEN_LONG;
  assign slot     = (count_q == 2'd3) ? 2'd0 : count_q;

  always_comb begin
    phase_d  = phase_q;
    kind_d   = kind_q;
    count_d  = count_q;
    store_d  = store_q;
    result_o = '0;
    case (phase_q)
      tkbfd_pkg::PH_PAYLOAD: begin
        store_d[slot] = byte_i;
        count_d       = count_q + 2'd1;
        if (count_d >= len) begin
          phase_d = tkbfd_pkg::PH_TRAILER;
        end
      end
      tkbfd_pkg::PH_TRAILER: begin
        if (byte_i == tkbfd_pkg::TRAILER) begin
          result_o.frame_done     = 1'b1;
          result_o.frame_kind     = is_align ? tkbfd_pkg::KIND_ALIGN : kind_q;
          result_o.payload_first  = store_q[0];
          result_o.payload_second = store_q[1];
          result_o.payload_third  = is_align ? 8'd0 : store_q[2];
          phase_d                 = tkbfd_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_d = tkbfd_pkg::PH_IDLE;
        if (byte_i inside {tkbfd_pkg::HDR_COLUMN, tkbfd_pkg::HDR_COLOUR,
                           tkbfd_pkg::HDR_ALIGN}) begin
          phase_d = tkbfd_pkg::PH_PAYLOAD;
          count_d = 2'd0;
        end
        case (byte_i)
          tkbfd_pkg::HDR_COLUMN: kind_d = tkbfd_pkg::KIND_COLUMN;
          tkbfd_pkg::HDR_COLOUR: kind_d = tkbfd_pkg::KIND_COLOUR;
          tkbfd_pkg::HDR_ALIGN:  kind_d = tkbfd_pkg::KIND_ALIGN;
          default:               kind_d = kind_q;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= tkbfd_pkg::PH_IDLE;
      kind_q     <= tkbfd_pkg::KIND_COLUMN;
      count_q    <= 2'd0;
      store_q[0] <= 8'd0;
      store_q[1] <= 8'd0;
      store_q[2] <= 8'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      count_q <= count_d;
      store_q <= store_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tkbfd_out_reg.sv -----
// ----------------------------------------------------------------------------
// tkbfd_out_reg
// Result register that holds one frame result until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tkbfd_out_reg (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  wire tkbfd_pkg::result_t result_i,
  output logic                    can_load_o,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output tkbfd_pkg::result_t      result_o
);

  logic               valid_q;
  tkbfd_pkg::result_t result_q;

  assign can_load_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_load_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && can_load_o) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

// ----- rtl/tkbfd_checker.sv -----
// ----------------------------------------------------------------------------
// tkbfd_checker
// Port-level checks of the deframer's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tkbfd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic       frame_done_i,
  input wire logic [1:0] frame_kind_i,
  input wire logic [7:0] payload_third_i
);

  // A result that is not taken stays offered.
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // Without a completed frame, the frame kind and the third payload byte are zero.
  a_idle_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !frame_done_i |-> frame_kind_i == tkbfd_pkg::KIND_COLUMN
                                     && payload_third_i == 8'd0)
    else $error("fields set without a completed frame");

  // Only the three frame kinds are ever reported.
  a_kind_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> frame_kind_i != 2'd3)
    else $error("undefined frame kind");

  // Alignment frames carry only two payload bytes.
  a_align_third : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_done_i && frame_kind_i == tkbfd_pkg::KIND_ALIGN
      |-> payload_third_i == 8'd0)
    else $error("alignment frame with third payload byte");

endmodule

bind three_kind_byte_frame_deframer_top tkbfd_checker u_tkbfd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .frame_done_i    (out_o.frame_done),
  .frame_kind_i    (out_o.frame_kind),
  .payload_third_i (out_o.payload_third)
);

`default_nettype wire

// ----- tb/sv/three_kind_byte_frame_deframer_top_tb.sv -----
// ----------------------------------------------------------------------------
// three_kind_byte_frame_deframer_top_tb
// Self-checking bench for the byte frame deframer. Bytes are sent over the
// input channel with random gaps, and the result channel is stalled at random.
// A predictor tracks the frame state machine for every accepted byte, and
// each result transfer is checked field by field against the oldest
// expectation. The run has these parts: directed corner cases, random frames
// mixed with noise and broken frames, a long output stall, and a final
// stretch with no idling.
// ----------------------------------------------------------------------------
`default_nettype none

module three_kind_byte_frame_deframer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni;

  tkbfd_in_if  in_if ();
  tkbfd_out_if out_if ();

  three_kind_byte_frame_deframer_top DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predicted deframer state.
  tkbfd_pkg::phase_e fr_phase = tkbfd_pkg::PH_IDLE;
  tkbfd_pkg::kind_e  fr_kind  = tkbfd_pkg::KIND_COLUMN;
  logic [1:0]        fr_count = 2'd0;
  logic [7:0]        fr_store [3] = '{8'h00, 8'h00, 8'h00};

  tkbfd_pkg::result_t frame_results_q [$];
  int      result_errors = 0;
  int      bytes_sent    = 0;
  bit      idle_on       = 1'b1;
  int      hold_cycles   = 0;
  int      stall_left    = 0;

  function automatic void open_frame(tkbfd_pkg::kind_e k);
    fr_kind  = k;
    fr_count = 2'd0;
    fr_phase = tkbfd_pkg::PH_PAYLOAD;
  endfunction

  // Advances the predicted state by one byte and returns the result it causes.
  function automatic tkbfd_pkg::result_t deframe_step(logic [7:0] b);
    tkbfd_pkg::result_t r;
    logic [1:0]         plen;
    r    = '0;
    plen = (fr_kind == tkbfd_pkg::KIND_COLUMN || fr_kind == tkbfd_pkg::KIND_COLOUR)
           ? tkbfd_pkg::LEN_LONG : tkbfd_pkg::LEN_SHORT;
    case (fr_phase)
      tkbfd_pkg::PH_PAYLOAD: begin
        fr_store[fr_count % 3] = b;
        fr_count = fr_count + 2'd1;
        if (fr_count >= plen) fr_phase = tkbfd_pkg::PH_TRAILER;
      end
      tkbfd_pkg::PH_TRAILER: begin
        if (b == tkbfd_pkg::TRAILER) begin
          r.frame_done     = 1'b1;
          r.frame_kind     = (plen == tkbfd_pkg::LEN_SHORT) ? tkbfd_pkg::KIND_ALIGN : fr_kind;
          r.payload_first  = fr_store[0];
          r.payload_second = fr_store[1];
          r.payload_third  = (plen == tkbfd_pkg::LEN_SHORT) ? 8'h00 : fr_store[2];
          fr_phase = tkbfd_pkg::PH_IDLE;
        end
      end
      default: begin
        fr_phase = tkbfd_pkg::PH_IDLE;
        if (b == tkbfd_pkg::HDR_COLUMN) open_frame(tkbfd_pkg::KIND_COLUMN);
        else if (b == tkbfd_pkg::HDR_COLOUR) open_frame(tkbfd_pkg::KIND_COLOUR);
        else if (b == tkbfd_pkg::HDR_ALIGN) open_frame(tkbfd_pkg::KIND_ALIGN);
      end
    endcase
    return r;
  endfunction

  // Result checking first, then prediction, so a byte accepted at this edge
  // can never be matched against a result leaving at the same edge.
  always @(posedge clk_i) begin
    tkbfd_pkg::result_t got;
    tkbfd_pkg::result_t want;
    if (out_if.valid && out_if.ready) begin
      got = '{out_if.frame_done, out_if.frame_kind, out_if.payload_first,
              out_if.payload_second, out_if.payload_third};
      if (frame_results_q.size() == 0) begin
        result_errors++;
        if (result_errors <= 10)
          $display("%0t: unexpected result done=%0b kind=%0d bytes=%02h %02h %02h",
                   $realtime, got.frame_done, got.frame_kind, got.payload_first,
                   got.payload_second, got.payload_third);
      end else begin
        want = frame_results_q.pop_front();
        if (got.frame_done !== want.frame_done || got.frame_kind !== want.frame_kind ||
            got.payload_first !== want.payload_first ||
            got.payload_second !== want.payload_second ||
            got.payload_third !== want.payload_third) begin
          result_errors++;
          if (result_errors <= 10)
            $display({"%0t: mismatch exp done=%0b kind=%0d bytes=%02h %02h %02h,",
                      " got done=%0b kind=%0d bytes=%02h %02h %02h"},
                     $realtime, want.frame_done, want.frame_kind, want.payload_first,
                     want.payload_second, want.payload_third, got.frame_done,
                     got.frame_kind, got.payload_first, got.payload_second,
                     got.payload_third);
        end
      end
    end
    if (in_if.valid && in_if.ready)
      frame_results_q.push_back(deframe_step(in_if.rx_byte));
  end

  // Result side: long hold-offs on request, otherwise random stall bursts.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready = 1'b0;
    end else if (hold_cycles > 0) begin
      out_if.ready = 1'b0;
      hold_cycles--;
    end else if (stall_left > 0) begin
      out_if.ready = 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_if.ready = 1'b0;
      stall_left   = $urandom_range(1, 19) - 1;
    end else begin
      out_if.ready = 1'b1;
    end
  end

  // Called and returns at a falling edge.
  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 6) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    in_if.valid   = 1'b1;
    in_if.rx_byte = b;
    do @(posedge clk_i); while (!in_if.ready);
    bytes_sent++;
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  task automatic wait_results_drained();
    while (frame_results_q.size() != 0) @(negedge clk_i);
  endtask

  // Payload data leans toward the header and trailer codes and the extremes.
  function automatic logic [7:0] payload_byte();
    case ($urandom_range(0, 11))
      0:       return tkbfd_pkg::HDR_COLUMN;
      1:       return tkbfd_pkg::HDR_COLOUR;
      2:       return tkbfd_pkg::HDR_ALIGN;
      3:       return tkbfd_pkg::TRAILER;
      4:       return 8'h00;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] non_trailer_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == tkbfd_pkg::TRAILER);
    return b;
  endfunction

  task automatic send_frame(input tkbfd_pkg::kind_e k, input bit junk);
    logic [7:0] hdr;
    case (k)
      tkbfd_pkg::KIND_COLUMN: hdr = tkbfd_pkg::HDR_COLUMN;
      tkbfd_pkg::KIND_COLOUR: hdr = tkbfd_pkg::HDR_COLOUR;
      default:                hdr = tkbfd_pkg::HDR_ALIGN;
    endcase
    send_byte(hdr);
    repeat ((k == tkbfd_pkg::KIND_ALIGN) ? tkbfd_pkg::LEN_SHORT : tkbfd_pkg::LEN_LONG)
      send_byte(payload_byte());
    if (junk) repeat ($urandom_range(1, 3)) send_byte(non_trailer_byte());
    send_byte(tkbfd_pkg::TRAILER);
  endtask

  task automatic test_directed();
    logic [7:0] seq [$] = '{
      // Idle noise, including a stray trailer.
      8'h00, tkbfd_pkg::TRAILER, 8'h7F,
      // Column frame with extreme payload values.
      tkbfd_pkg::HDR_COLUMN, 8'h00, 8'hFF, 8'h80, tkbfd_pkg::TRAILER,
      // Alignment frame: third payload byte must read as zero.
      tkbfd_pkg::HDR_ALIGN, 8'hAA, 8'h55, tkbfd_pkg::TRAILER,
      // Colour frame carrying header and trailer codes as data, then header
      // codes while waiting for the trailer.
      tkbfd_pkg::HDR_COLOUR, tkbfd_pkg::TRAILER, tkbfd_pkg::HDR_ALIGN,
      tkbfd_pkg::HDR_COLUMN, tkbfd_pkg::HDR_COLOUR, tkbfd_pkg::HDR_COLUMN,
      tkbfd_pkg::TRAILER,
      // Alignment frame with junk before its trailer.
      tkbfd_pkg::HDR_ALIGN, tkbfd_pkg::HDR_COLOUR, tkbfd_pkg::HDR_COLUMN,
      tkbfd_pkg::HDR_ALIGN, 8'h00, tkbfd_pkg::TRAILER
    };
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic test_random_frames(input int n_bytes);
    int stop_at;
    int r;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        send_frame(tkbfd_pkg::kind_e'($urandom_range(0, 2)), $urandom_range(0, 3) == 0);
      end else if (r < 9) begin
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        // Broken frame: a header with a short payload; what follows is
        // absorbed as payload.
        send_byte(($urandom_range(0, 1) == 0) ? tkbfd_pkg::HDR_COLUMN
                                              : tkbfd_pkg::HDR_ALIGN);
        send_byte(payload_byte());
      end
    end
  endtask

  task automatic test_output_hold();
    hold_cycles = 80;
    repeat (4) send_frame(tkbfd_pkg::kind_e'($urandom_range(0, 2)), 1'b0);
    // Sender stays quiet until every result is out.
    wait_results_drained();
    send_frame(tkbfd_pkg::KIND_COLOUR, 1'b1);
  endtask

  task automatic test_full_rate(input int n_bytes);
    idle_on = 1'b0;
    wait (stall_left == 0);
    @(negedge clk_i);
    test_random_frames(n_bytes);
  endtask

  initial begin
    int spins;
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.rx_byte = 8'h00;
    out_if.ready  = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random_frames(400);
    test_output_hold();
    test_full_rate(80);

    spins = 0;
    while (frame_results_q.size() != 0 && spins < 20000) begin
      @(posedge clk_i);
      spins++;
    end
    repeat (8) @(posedge clk_i);
    if (result_errors == 0 && frame_results_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (frame_results_q.size() != 0)
        $display("%0d expected results never arrived", frame_results_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d results outstanding", frame_results_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
